// ===== rtl/core/ble_pkg.sv =====
// ----------------------------------------------------------------------------
// ble_pkg
// Shared widths, register indexes, reset values and handshake structs for the
// battery level estimator.
// ----------------------------------------------------------------------------
package ble_pkg;

  // Field widths
  localparam int SAMPLE_W  = 12;
  localparam int MV_W      = 15;
  localparam int PCT_W     = 7;
  localparam int NUM_BP    = 6;
  localparam int PCT_REG_W = NUM_BP * PCT_W;
  localparam int CFG_W     = PCT_REG_W;
  localparam int CFG_IDX_W = 3;

  // Ring depth default and arithmetic constants
  localparam int DEF_WINDOW   = 60;
  localparam int SCALE_FACTOR = 6;
  localparam logic [PCT_W-1:0] FULL_PERCENT = PCT_W'(100);
  localparam logic [PCT_W-1:0] ZERO_PERCENT = '0;

  // Shared divider: quotient bits and numerator width
  // (numerator covers a sum over 256 samples and the interpolation product)
  localparam int QUO_W     = MV_W;
  localparam int DIV_NUM_W = MV_W + 8;
  localparam int DIV_CNT_W = $clog2(QUO_W + 1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BP_FIRST = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BP_LAST  = CFG_IDX_W'(NUM_BP - 1);
  localparam logic [CFG_IDX_W-1:0] REG_PCTS     = CFG_IDX_W'(NUM_BP);

  // Reset values of the breakpoint table
  localparam logic [MV_W-1:0] BP_RESET [NUM_BP] = '{
    MV_W'(3000), MV_W'(3450), MV_W'(3650), MV_W'(3800), MV_W'(3950), MV_W'(4100)
  };
  localparam logic [PCT_REG_W-1:0] PCTS_RESET = PCT_REG_W'(64'd3457575160320);

  // Request to the shared divider
  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [MV_W-1:0]      den;
  } div_req_t;

  // Result of the percent mapper
  typedef struct packed {
    logic                 done;
    logic                 direct;  // percent known without a division
    logic [PCT_W-1:0]     pct;
    logic [DIV_NUM_W-1:0] num;
    logic [MV_W-1:0]      span;
  } map_res_t;

endpackage

// ===== rtl/core/ble_ring.sv =====
// ----------------------------------------------------------------------------
// ble_ring
// Sample ring in a synchronous memory with running sum, fill count and write
// pointer. One push reads the slot, then replaces it and updates the sum.
// ----------------------------------------------------------------------------
module ble_ring
  import ble_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic [MV_W-1:0]                 push_data,
  output logic                            done,
  output logic [MV_W+$clog2(WINDOW)-1:0]  sum,
  output logic [$clog2(WINDOW+1)-1:0]     count
);

  localparam int SUM_W = MV_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [MV_W-1:0]  ring [WINDOW];
  logic [MV_W-1:0]  rd_data;
  logic [MV_W-1:0]  held;
  logic [PTR_W-1:0] wp;
  logic             pend;
  logic             full;
  logic [SUM_W-1:0] sum_next;

  // Memory: read the slot at the write pointer, write the held sample there in the cycle after a push
  always_ff @(posedge clk) begin
    if (pend) begin
      ring[wp] <= held;
    end
    rd_data <= ring[wp];
  end

  // Hold the new sample while the old slot is read
  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_data;
    end
  end

  assign full = (count == CNT_W'(WINDOW));

  // Drop the oldest sample once the window is full
  always_comb begin
    if (full) begin
      sum_next = sum - SUM_W'(rd_data) + SUM_W'(held);
    end else begin
      sum_next = sum + SUM_W'(held);
    end
  end

  // Advance sum, count and pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      done  <= 1'b0;
      sum   <= '0;
      count <= '0;
      wp    <= '0;
    end else begin
      pend <= push;
      done <= pend;
      if (pend) begin
        sum <= sum_next;
        if (!full) begin
          count <= count + CNT_W'(1);
        end
        if (wp == PTR_W'(WINDOW - 1)) begin
          wp <= '0;
        end else begin
          wp <= wp + PTR_W'(1);
        end
      end
    end
  end

endmodule

// ===== rtl/core/ble_div.sv =====
// ----------------------------------------------------------------------------
// ble_div
// Restoring divider, one quotient bit per cycle. Shared by the average and
// the interpolation; the quotient must fit in QUO_W bits.
// ----------------------------------------------------------------------------
module ble_div
  import ble_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [QUO_W-1:0] quo
);

  localparam int DSH_W = MV_W + QUO_W - 1;
  localparam int PAD_W = DSH_W - DIV_NUM_W;

  logic [DIV_NUM_W-1:0] rem;
  logic [DSH_W-1:0]     dsh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 busy;
  logic                 ge;

  assign ge = ({{PAD_W{1'b0}}, rem} >= dsh);

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(QUO_W);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_W'(1);
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Subtract the shifted divisor where it fits, shift in the quotient bit
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.num;
      dsh <= {req.den, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - dsh[DIV_NUM_W-1:0];
      end
      dsh <= dsh >> 1;
      quo <= {quo[QUO_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/ble_map.sv =====
// ----------------------------------------------------------------------------
// ble_map
// Breakpoint registers and percent mapping: segment search in one stage,
// interpolation numerator in the next.
// ----------------------------------------------------------------------------
module ble_map
  import ble_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 eval,
  input  logic [MV_W-1:0]      avg,
  output map_res_t             res
);

  logic [MV_W-1:0]      bp [NUM_BP];
  logic [PCT_REG_W-1:0] pcts;

  logic                 below, above, found;
  logic [PCT_W-1:0]     lo, hi;
  logic [MV_W-1:0]      base, span;

  logic                 s1_v, s1_direct;
  logic [PCT_W-1:0]     s1_pct, s1_lo;
  logic signed [PCT_W:0] s1_dp;
  logic [MV_W-1:0]      s1_span, s1_off;

  logic [PCT_W+MV_W-1:0]        p_lo;
  logic signed [PCT_W+MV_W+1:0] p_off;
  logic signed [PCT_W+MV_W+1:0] num_s;

  logic                 r_done, r_direct;
  logic [PCT_W-1:0]     r_pct;
  logic [DIV_NUM_W-1:0] r_num;
  logic [MV_W-1:0]      r_span;

  // Configuration writes; indexes past the table are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_BP; k++) begin
        bp[k] <= BP_RESET[k];
      end
      pcts <= PCTS_RESET;
    end else if (cfg_we) begin
      for (int k = 0; k < NUM_BP; k++) begin
        if (cfg_index == REG_BP_FIRST + CFG_IDX_W'(k)) begin
          bp[k] <= cfg_data[MV_W-1:0];
        end
      end
      if (cfg_index == REG_PCTS) begin
        pcts <= cfg_data[PCT_REG_W-1:0];
      end
    end
  end

  // Pick the first segment that holds the average
  always_comb begin
    below = (avg < bp[0]);
    above = (avg >= bp[NUM_BP-1]);
    found = 1'b0;
    lo    = '0;
    hi    = '0;
    base  = '0;
    span  = '0;
    for (int k = 0; k < NUM_BP - 1; k++) begin
      if (!found && (avg >= bp[k]) && (avg < bp[k+1])) begin
        found = 1'b1;
        lo    = pcts[PCT_W*k +: PCT_W];
        hi    = pcts[PCT_W*(k+1) +: PCT_W];
        base  = bp[k];
        span  = bp[k+1] - bp[k];
      end
    end
  end

  // Stage 1: register the segment or a fixed percent
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= eval;
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      s1_direct <= below || above || !found;
      s1_pct    <= (above && !below) ? FULL_PERCENT : ZERO_PERCENT;
      s1_lo     <= lo;
      s1_dp     <= $signed({1'b0, hi}) - $signed({1'b0, lo});
      s1_span   <= span;
      s1_off    <= avg - base;
    end
  end

  // Interpolation numerator, never negative since the offset is below the span
  assign p_lo  = s1_lo * s1_span;
  assign p_off = $signed({1'b0, s1_off}) * s1_dp;
  assign num_s = $signed({2'b00, p_lo}) + p_off;

  // Stage 2: register the division request
  always_ff @(posedge clk) begin
    if (rst) begin
      r_done <= 1'b0;
    end else begin
      r_done <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      r_direct <= s1_direct;
      r_pct    <= s1_pct;
      r_num    <= num_s[DIV_NUM_W-1:0];
      r_span   <= s1_span;
    end
  end

  assign res.done   = r_done;
  assign res.direct = r_direct;
  assign res.pct    = r_pct;
  assign res.num    = r_num;
  assign res.span   = r_span;

endmodule

// ===== rtl/core/battery_level_estimator_unit.sv =====
// From an accepted sample to its result in the output register: ring update,
//   average divide, mapping, percent divide, output register; the percent divide
//   is skipped when the percent needs no division.
// Samples: one at a time through the shared bit-serial divider; a new sample is
//   taken only when idle; a stalled result holds the sequencer in its output step.
// Reset: breakpoints return to defaults, sum, count and pointer clear; ring kept.
// ----------------------------------------------------------------------------
// battery_level_estimator_unit
// Moving-average battery gauge: scaled samples in a memory ring, average by
// division, then piecewise-linear mapping to a charge percentage.
// ----------------------------------------------------------------------------
module battery_level_estimator_unit
  import ble_pkg::*;
#(
  parameter int WINDOW = DEF_WINDOW
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SAMPLE_W-1:0]  sample_mv,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [PCT_W-1:0]     battery_percent,
  output logic [MV_W-1:0]      average_mv
);

  localparam int SUM_W = MV_W + $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RING = 3'd1;
  localparam logic [2:0] ST_AVG  = 3'd2;
  localparam logic [2:0] ST_MAP  = 3'd3;
  localparam logic [2:0] ST_PCT  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]       state, state_next;
  logic             in_take;
  logic             out_free;
  logic [MV_W-1:0]  scaled;
  logic             ring_done;
  logic [SUM_W-1:0] ring_sum;
  logic [CNT_W-1:0] ring_count;
  div_req_t         div_req;
  logic             div_done;
  logic [QUO_W-1:0] div_quo;
  map_res_t         map_res;
  logic             map_eval;
  logic [MV_W-1:0]  avg;
  logic [PCT_W-1:0] pct;

  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign scaled   = MV_W'(sample_mv) * MV_W'(SCALE_FACTOR);
  assign map_eval = (state == ST_AVG) && div_done;

  ble_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .push      (in_take),
    .push_data (scaled),
    .done      (ring_done),
    .sum       (ring_sum),
    .count     (ring_count)
  );

  // Divider request: the average first, then the interpolation
  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = DIV_NUM_W'(ring_sum);
    div_req.den   = MV_W'(ring_count);
    if (state == ST_RING) begin
      div_req.start = ring_done;
    end else if (state == ST_MAP) begin
      div_req.start = map_res.done && !map_res.direct;
      div_req.num   = map_res.num;
      div_req.den   = map_res.span;
    end
  end

  ble_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  ble_map u_map (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .eval      (map_eval),
    .avg       (div_quo[MV_W-1:0]),
    .res       (map_res)
  );

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_take) state_next = ST_RING;
      ST_RING: if (ring_done) state_next = ST_AVG;
      ST_AVG:  if (div_done) state_next = ST_MAP;
      ST_MAP: begin
        if (map_res.done) begin
          state_next = map_res.direct ? ST_OUT : ST_PCT;
        end
      end
      ST_PCT:  if (div_done) state_next = ST_OUT;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the average and the percent
  always_ff @(posedge clk) begin
    if (map_eval) begin
      avg <= div_quo[MV_W-1:0];
    end
    if (state == ST_MAP && map_res.done) begin
      pct <= map_res.pct;
    end else if (state == ST_PCT && div_done) begin
      pct <= div_quo[PCT_W-1:0];
    end
  end

  // Output register: hold until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      battery_percent <= pct;
      average_mv      <= avg;
    end
  end

  // Checks
  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_OUT))
    else $error("result presented outside the output step");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_AVG || state == ST_PCT))
    else $error("divider finished with no waiting step");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ring_count <= CNT_W'(WINDOW))
    else $error("fill count past the window");

  a_take_starts: assert property (@(posedge clk) disable iff (rst)
    in_take |=> (state == ST_RING))
    else $error("accepted sample did not start a ring update");

endmodule
